/* sv/wrqn_pkg.sv */
// Shared types, constants and arithmetic helpers of the wall reflection block.
package wrqn_pkg;

   localparam logic [15:0] RESTITUTION_ONE = 16'h8000;
   localparam int QUOT_BITS = 32;
   localparam int DIV_CNT_W = $clog2(QUOT_BITS);

   typedef struct packed {
      logic [31:0]        node_weight;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [31:0]        face_area;
      logic               last_node;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]        out_weight;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_vel_z;
      logic               weight_saturated;
      logic               last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0]        weight;
      logic signed [31:0] refl_x;
      logic signed [31:0] refl_y;
      logic signed [31:0] refl_z;
   } store_entry_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DOT_V, OP_DN, OP_PROJ, OP_REST, OP_REFL, OP_DOT_R,
      OP_DR, OP_FLUX_OUT, OP_FLUX_W, OP_FLUX_SUM, OP_ACC_OUT, OP_EMIT_START,
      OP_READ, OP_SCALE_MUL, OP_SCALE_SUM, OP_DIV_START, OP_DIV_STEP,
      OP_RESULT, OP_NEXT, OP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic full;
      logic last_in;
      logic scale_en;
      logic div_last;
      logic emit_last;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DOT_V, S_DN, S_PROJ, S_REST, S_REFL, S_DOT_R, S_DR,
      S_FLUX_OUT, S_FLUX_W, S_FLUX_SUM, S_ACC_OUT, S_EMIT_START, S_READ,
      S_SCALE_MUL, S_SCALE_SUM, S_DIV_START, S_DIV_STEP, S_RESULT, S_OUT
   } ctrl_state_type;

   function automatic logic [31:0] clamp_mag(input logic signed [36:0] x);
      logic [31:0] r;
      if (x > 37'sh0080000000) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
      logic signed [31:0] r;
      if (x > 42'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -42'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

endpackage

/* sv/wrqn_ctrl.sv */
// Controller state machine that sequences the wall reflection datapath.
module wrqn_ctrl import wrqn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_node,
   output logic          req_stall,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_op_type     op
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = OP_LOAD;
               if (status.full) begin
                  state_in = req_last_node ? S_EMIT_START : S_IDLE;
               end else begin
                  state_in = S_DOT_V;
               end
            end
         end
         S_DOT_V: begin
            op = OP_DOT_V;
            state_in = S_DN;
         end
         S_DN: begin
            op = OP_DN;
            state_in = S_PROJ;
         end
         S_PROJ: begin
            op = OP_PROJ;
            state_in = S_REST;
         end
         S_REST: begin
            op = OP_REST;
            state_in = S_REFL;
         end
         S_REFL: begin
            op = OP_REFL;
            state_in = S_DOT_R;
         end
         S_DOT_R: begin
            op = OP_DOT_R;
            state_in = S_DR;
         end
         S_DR: begin
            op = OP_DR;
            state_in = S_FLUX_OUT;
         end
         S_FLUX_OUT: begin
            op = OP_FLUX_OUT;
            state_in = S_FLUX_W;
         end
         S_FLUX_W: begin
            op = OP_FLUX_W;
            state_in = S_FLUX_SUM;
         end
         S_FLUX_SUM: begin
            op = OP_FLUX_SUM;
            state_in = S_ACC_OUT;
         end
         S_ACC_OUT: begin
            op = OP_ACC_OUT;
            state_in = status.last_in ? S_EMIT_START : S_IDLE;
         end
         S_EMIT_START: begin
            op = OP_EMIT_START;
            state_in = S_READ;
         end
         S_READ: begin
            op = OP_READ;
            state_in = status.scale_en ? S_SCALE_MUL : S_RESULT;
         end
         S_SCALE_MUL: begin
            op = OP_SCALE_MUL;
            state_in = S_SCALE_SUM;
         end
         S_SCALE_SUM: begin
            op = OP_SCALE_SUM;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            op = OP_DIV_START;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            op = OP_DIV_STEP;
            state_in = status.div_last ? S_RESULT : S_DIV_STEP;
         end
         S_RESULT: begin
            op = OP_RESULT;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               op = status.emit_last ? OP_FINISH : OP_NEXT;
               state_in = status.emit_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* sv/wrqn_datapath.sv */
// Datapath of the wall reflection block: lane multipliers, flux unit, divider and node store.
module wrqn_datapath import wrqn_pkg::*; #(
   parameter int MAX_NODES = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_op_type       op,
   input  req_payload_type req_payload,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data,
   output dp_status_type   status,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);

   req_payload_type       in_ff;
   logic [15:0]           restitution_ff;
   logic signed [54:0]    prod_ff [3];
   logic signed [54:0]    prod_in [3];
   logic signed [37:0]    mul_a [3];
   logic signed [16:0]    mul_b [3];
   logic signed [31:0]    vel [3];
   logic signed [15:0]    nrm [3];
   logic signed [37:0]    vn_ff [3];
   logic signed [31:0]    refl_ff [3];
   logic signed [31:0]    refl_in [3];
   logic signed [36:0]    dn_ff, dr_ff, dot_shift, mag_src;
   logic signed [56:0]    dot_sum;
   logic [63:0]           flux_a_ff, fh_ff, fl_ff;
   logic [31:0]           flux_w;
   logic [95:0]           nsum_ff, nsum_in;
   logic                  in_en_ff, out_en_ff;
   logic [63:0]           inflow_ff, outflow_ff, den_ff, rem_ff;
   logic [31:0]           lo_ff, quot_ff;
   logic                  sat_ff;
   logic [64:0]           div_t, div_diff;
   logic                  div_ge;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [CNT_W-1:0]      count_ff, emit_idx_ff;
   store_entry_type       mem [MAX_NODES];
   store_entry_type       rd_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff;

   assign vel[0] = in_ff.vel_x;
   assign vel[1] = in_ff.vel_y;
   assign vel[2] = in_ff.vel_z;
   assign nrm[0] = in_ff.normal_x;
   assign nrm[1] = in_ff.normal_y;
   assign nrm[2] = in_ff.normal_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (op)
            OP_PROJ: begin
               mul_a[k] = 38'(dn_ff);
               mul_b[k] = 17'(nrm[k]);
            end
            OP_REST: begin
               mul_a[k] = 38'(prod_ff[k] >>> 14);
               mul_b[k] = $signed({1'b0, restitution_ff});
            end
            OP_DOT_R: begin
               mul_a[k] = 38'(refl_ff[k]);
               mul_b[k] = 17'(nrm[k]);
            end
            default: begin
               mul_a[k] = 38'(vel[k]);
               mul_b[k] = 17'(nrm[k]);
            end
         endcase
         prod_in[k] = 55'(mul_a[k]) * 55'(mul_b[k]);
         refl_in[k] = sat32(42'(vel[k]) - 42'(vn_ff[k]) - 42'(prod_ff[k] >>> 15));
      end
   end

   assign dot_sum   = 57'(prod_ff[0]) + 57'(prod_ff[1]) + 57'(prod_ff[2]);
   assign dot_shift = 37'(dot_sum >>> 14);
   assign mag_src   = (op == OP_FLUX_OUT) ? -dr_ff : dn_ff;
   assign flux_w    = (op == OP_SCALE_MUL) ? rd_ff.weight : in_ff.node_weight;
   assign nsum_in   = {fh_ff, 32'h0} + {32'h0, fl_ff};
   assign div_t     = {rem_ff, lo_ff[31]};
   assign div_diff  = div_t - {1'b0, den_ff};
   assign div_ge    = (div_t >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            in_ff <= req_payload;
         end
         OP_DOT_V, OP_DOT_R: begin
            prod_ff <= prod_in;
         end
         OP_DN: begin
            dn_ff <= dot_shift;
         end
         OP_PROJ: begin
            prod_ff   <= prod_in;
            flux_a_ff <= 64'(clamp_mag(mag_src)) * 64'(in_ff.face_area);
            in_en_ff  <= (dn_ff > 37'sd0);
         end
         OP_REST: begin
            for (int k = 0; k < 3; k++) begin
               vn_ff[k] <= 38'(prod_ff[k] >>> 14);
            end
            prod_ff <= prod_in;
            fh_ff   <= 64'(flux_a_ff[63:32]) * 64'(flux_w);
            fl_ff   <= 64'(flux_a_ff[31:0]) * 64'(flux_w);
         end
         OP_REFL: begin
            refl_ff <= refl_in;
            nsum_ff <= nsum_in;
         end
         OP_DR: begin
            dr_ff <= dot_shift;
         end
         OP_FLUX_OUT: begin
            flux_a_ff <= 64'(clamp_mag(mag_src)) * 64'(in_ff.face_area);
            out_en_ff <= (dr_ff < 37'sd0);
         end
         OP_FLUX_W, OP_SCALE_MUL: begin
            fh_ff <= 64'(flux_a_ff[63:32]) * 64'(flux_w);
            fl_ff <= 64'(flux_a_ff[31:0]) * 64'(flux_w);
         end
         OP_FLUX_SUM, OP_SCALE_SUM: begin
            nsum_ff <= nsum_in;
         end
         OP_ACC_OUT: begin
            mem[count_ff[IDX_W-1:0]] <= {in_ff.node_weight, refl_ff[0], refl_ff[1], refl_ff[2]};
         end
         OP_EMIT_START: begin
            den_ff <= (&outflow_ff) ? outflow_ff : outflow_ff + 64'd1;
         end
         OP_READ: begin
            rd_ff     <= mem[emit_idx_ff[IDX_W-1:0]];
            flux_a_ff <= inflow_ff;
         end
         OP_DIV_START: begin
            rem_ff  <= nsum_ff[95:32];
            lo_ff   <= nsum_ff[31:0];
            sat_ff  <= (nsum_ff[95:32] >= den_ff);
            quot_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff  <= div_ge ? div_diff[63:0] : div_t[63:0];
            lo_ff   <= {lo_ff[30:0], 1'b0};
            quot_ff <= {quot_ff[30:0], div_ge};
         end
         OP_RESULT: begin
            rsp_ff.out_weight       <= !status.scale_en ? rd_ff.weight
                                       : (sat_ff ? '1 : quot_ff);
            rsp_ff.out_vel_x        <= rd_ff.refl_x;
            rsp_ff.out_vel_y        <= rd_ff.refl_y;
            rsp_ff.out_vel_z        <= rd_ff.refl_z;
            rsp_ff.weight_saturated <= status.scale_en & sat_ff;
            rsp_ff.last_out         <= status.emit_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= RESTITUTION_ONE;
         count_ff       <= '0;
         emit_idx_ff    <= '0;
         inflow_ff      <= '0;
         outflow_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            restitution_ff <= csr_write_data;
         end
         unique case (op)
            OP_DOT_R: begin
               if (in_en_ff) begin
                  inflow_ff <= sat_add64(inflow_ff, nsum_ff[95:32]);
               end
            end
            OP_ACC_OUT: begin
               if (out_en_ff) begin
                  outflow_ff <= sat_add64(outflow_ff, nsum_ff[95:32]);
               end
               count_ff <= count_ff + 1'b1;
            end
            OP_EMIT_START: begin
               emit_idx_ff <= '0;
            end
            OP_DIV_START: begin
               div_cnt_ff <= '0;
            end
            OP_DIV_STEP: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            OP_RESULT: begin
               rsp_valid_ff <= 1'b1;
            end
            OP_NEXT: begin
               rsp_valid_ff <= 1'b0;
               emit_idx_ff  <= emit_idx_ff + 1'b1;
            end
            OP_FINISH: begin
               rsp_valid_ff <= 1'b0;
               count_ff     <= '0;
               inflow_ff    <= '0;
               outflow_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.full      = (count_ff == CNT_W'(MAX_NODES));
   assign status.last_in   = in_ff.last_node;
   assign status.scale_en  = (restitution_ff < RESTITUTION_ONE);
   assign status.div_last  = (div_cnt_ff == DIV_CNT_W'(QUOT_BITS - 1));
   assign status.emit_last = (CNT_W'(emit_idx_ff + 1'b1) == count_ff);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* sv/wall_reflect_quadrature_nodes.sv */
// Top level of the wall reflection block: controller and datapath.
//
//   channel   direction  handshake            contents
//   req_      in         req_valid/req_stall  one quadrature node of a face
//   rsp_      out        rsp_valid/rsp_stall  one reflected, rescaled node
//   csr_      in         csr_write_enable     restitution register
//
// A stored node passes through the chain of shared lane multipliers and the flux unit;
// a node beyond MAX_NODES is dropped, and if it is the face's last node the emit starts.
// At face end each stored node is read out and sent, held while the output is stalled;
// below unit restitution its weight is rescaled first by the one-bit-per-cycle divider.
// Reset is synchronous and clears the face state and sets restitution to one.
// The input is stalled while the controller is busy with a node or emitting results.
module wall_reflect_quadrature_nodes import wrqn_pkg::*; #(
   parameter int MAX_NODES = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data
);

   dp_op_type     op;
   dp_status_type status;

   wrqn_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_node (req_payload.last_node),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .op            (op)
   );

   wrqn_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule
